FILE: hw/rtl/soa_pkg.sv
// shared types and codes for the slab object allocator
// no dependencies; imported by soa_regs, slab_object_allocator_top, slab_alloc_checker and tb
`default_nettype none

package soa_pkg;

  // pool geometry, fixed by the item field widths
  localparam int NUM_SLABS = 16;
  localparam int MAX_OBJS  = 64;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // register index within the apb window (paddr[2])
  localparam logic REG_OBJS_PER_SLAB = 1'b0;
  localparam logic REG_SLAB_LIMIT    = 1'b1;

  localparam logic [6:0] OBJS_PER_SLAB_RST = 7'd64;
  localparam logic [4:0] SLAB_LIMIT_RST    = 5'd16;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_OOM   = 2'd1,
    ST_FREED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TAG_PART = 2'd0,
    TAG_FULL = 2'd1,
    TAG_FREE = 2'd2,
    TAG_NONE = 2'd3
  } tag_e;

  typedef struct packed {
    logic       command;
    logic [3:0] free_slab;
    logic [5:0] free_object;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] slab;
    logic [5:0] object;
  } rsp_t;

  typedef struct packed {
    logic [6:0] objs_per_slab;
    logic [4:0] slab_limit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/soa_regs.sv
// apb configuration registers of the slab object allocator
// depends on soa_pkg
`default_nettype none

module soa_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output soa_pkg::cfg_t      cfg_o
);
  import soa_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.objs_per_slab <= OBJS_PER_SLAB_RST;
      cfg_q.slab_limit    <= SLAB_LIMIT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_OBJS_PER_SLAB: cfg_q.objs_per_slab <= pwdata[6:0];
        REG_SLAB_LIMIT:    cfg_q.slab_limit    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OBJS_PER_SLAB: prdata = {25'd0, cfg_q.objs_per_slab};
      REG_SLAB_LIMIT:    prdata = {27'd0, cfg_q.slab_limit};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/slab_object_allocator_top.sv
// slab object allocator: one item at a time; a new item is accepted only once the
// result of the last one has been put on the output; an alloc that opens a new slab
// threads its free chain through the link memory (one write port).
// reset empties all lists and the pool count; memories are not cleared
// and need no clearing pass, config returns to 64 objects and 16 slabs
`default_nettype none

module slab_object_allocator_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire soa_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output soa_pkg::rsp_t      out_data_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);
  import soa_pkg::*;

  localparam int SW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int LW = $clog2(NUM_SLABS + 1);
  localparam int OW = (MAX_OBJS > 1) ? $clog2(MAX_OBJS) : 1;
  localparam int CW = $clog2(MAX_OBJS + 1);
  localparam int NE = NUM_SLABS * MAX_OBJS;
  localparam int AW = (NE > 1) ? $clog2(NE) : 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_SLABS);

  typedef struct packed {
    logic [OW-1:0] head;
    logic [CW-1:0] cnt;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
    tag_e          tag;
  } slab_t;

  typedef enum logic [3:0] {
    IDLE, SWEEP, LOAD, POP_RD, POP_WR, MV_CHECK, UL_P_WR, UL_N, UL_N_WR,
    PU, PU_WR, MV_WB, FIN
  } state_e;

  function automatic logic [AW-1:0] laddr(logic [SW-1:0] s, logic [OW-1:0] o);
    return AW'(AW'(s) * AW'(MAX_OBJS) + AW'(o));
  endfunction

  function automatic logic is_slab(logic [LW-1:0] v);
    return v < NIL;
  endfunction

  cfg_t cfg;

  soa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // memories
  slab_t         smem [NUM_SLABS];
  logic [OW-1:0] lmem [NE];

  logic          sm_we;
  logic [SW-1:0] sm_waddr, sm_raddr;
  slab_t         sm_wdata, sm_rd_q;
  logic          lm_we;
  logic [AW-1:0] lm_waddr, lm_raddr;
  logic [OW-1:0] lm_wdata, lm_rd_q;

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      smem[sm_waddr] <= sm_wdata;
    end
    sm_rd_q <= smem[sm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) begin
      lmem[lm_waddr] <= lm_wdata;
    end
    lm_rd_q <= lmem[lm_raddr];
  end

  // control state
  state_e        state_q;
  logic [LW-1:0] heads_q [3];
  logic [LW-1:0] taken_q;
  logic          out_valid_q;
  rsp_t          out_q;
  req_t          req_q;
  rsp_t          res_q;
  slab_t         e_q;
  logic [SW-1:0] s_q;
  logic [OW-1:0] o_q;
  logic [OW-1:0] i_q;
  logic [LW-1:0] h_q;
  tag_e          mv_tag_q;
  logic          ret_pop_q;

  logic [CW-1:0] cap;
  logic [LW-1:0] lim;
  logic          accept;
  logic          free_ok;
  logic          oom;
  logic          sweep_last;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] cnt_inc;

  always_comb begin
    if (cfg.objs_per_slab == 7'd0) begin
      cap = CW'(1);
    end else if (32'(cfg.objs_per_slab) > MAX_OBJS) begin
      cap = CW'(MAX_OBJS);
    end else begin
      cap = CW'(cfg.objs_per_slab);
    end
    lim = (32'(cfg.slab_limit) > NUM_SLABS) ? NIL : LW'(cfg.slab_limit);
  end

  assign in_ready_o  = (state_q == IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign free_ok     = (32'(in_data_i.free_slab) < 32'(taken_q)) &&
                       (32'(in_data_i.free_object) < 32'(cap));
  assign oom         = (in_data_i.command == CMD_ALLOC) &&
                       !is_slab(heads_q[TAG_PART]) && !is_slab(heads_q[TAG_FREE]) &&
                       !(taken_q < lim);
  assign sweep_last  = (CW'(i_q) == cap - CW'(1));
  assign cnt_dec     = (e_q.cnt != '0) ? e_q.cnt - CW'(1) : e_q.cnt;
  assign cnt_inc     = sm_rd_q.cnt + CW'(1);

  // memory port control
  always_comb begin
    sm_we    = 1'b0;
    sm_waddr = s_q;
    sm_wdata = e_q;
    sm_raddr = s_q;
    lm_we    = 1'b0;
    lm_waddr = laddr(s_q, i_q);
    lm_wdata = sweep_last ? '0 : i_q + OW'(1);
    lm_raddr = laddr(s_q, e_q.head);
    case (state_q)
      IDLE: begin
        if (in_data_i.command == CMD_FREE) begin
          sm_raddr = SW'(in_data_i.free_slab);
        end else if (is_slab(heads_q[TAG_PART])) begin
          sm_raddr = SW'(heads_q[TAG_PART]);
        end else begin
          sm_raddr = SW'(heads_q[TAG_FREE]);
        end
      end
      SWEEP: lm_we = 1'b1;
      LOAD: begin
        // free: push the object onto its slab chain
        lm_waddr = laddr(s_q, o_q);
        lm_wdata = sm_rd_q.head;
        lm_we    = (req_q.command == CMD_FREE) && (sm_rd_q.cnt < cap);
      end
      MV_CHECK: sm_raddr = SW'(e_q.prv);
      UL_P_WR: begin
        sm_we        = 1'b1;
        sm_waddr     = SW'(e_q.prv);
        sm_wdata     = sm_rd_q;
        sm_wdata.nxt = e_q.nxt;
      end
      UL_N: sm_raddr = SW'(e_q.nxt);
      UL_N_WR: begin
        sm_we        = 1'b1;
        sm_waddr     = SW'(e_q.nxt);
        sm_wdata     = sm_rd_q;
        sm_wdata.prv = e_q.prv;
      end
      PU: sm_raddr = SW'(heads_q[mv_tag_q]);
      PU_WR: begin
        sm_we        = 1'b1;
        sm_waddr     = SW'(h_q);
        sm_wdata     = sm_rd_q;
        sm_wdata.prv = LW'(s_q);
      end
      MV_WB: sm_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      heads_q     <= '{default: NIL};
      taken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (accept) begin
            req_q <= in_data_i;
            res_q <= '{status: oom ? ST_OOM : ST_FREED, slab: '0, object: '0};
            if (in_data_i.command == CMD_FREE) begin
              s_q     <= SW'(in_data_i.free_slab);
              o_q     <= OW'(in_data_i.free_object);
              state_q <= free_ok ? LOAD : FIN;
            end else if (is_slab(heads_q[TAG_PART])) begin
              s_q     <= SW'(heads_q[TAG_PART]);
              state_q <= LOAD;
            end else if (is_slab(heads_q[TAG_FREE])) begin
              s_q     <= SW'(heads_q[TAG_FREE]);
              state_q <= LOAD;
            end else if (taken_q < lim) begin
              s_q     <= SW'(taken_q);
              taken_q <= taken_q + LW'(1);
              i_q     <= '0;
              state_q <= SWEEP;
            end else begin
              state_q <= FIN;
            end
          end
        end
        SWEEP: begin
          // thread the new slab's objects in ascending order
          if (sweep_last) begin
            e_q       <= '{head: '0, cnt: cap, nxt: NIL, prv: NIL, tag: TAG_NONE};
            mv_tag_q  <= TAG_PART;
            ret_pop_q <= 1'b1;
            state_q   <= MV_CHECK;
          end else begin
            i_q <= i_q + OW'(1);
          end
        end
        LOAD: begin
          if (req_q.command == CMD_ALLOC) begin
            e_q       <= sm_rd_q;
            mv_tag_q  <= TAG_PART;
            ret_pop_q <= 1'b1;
            state_q   <= MV_CHECK;
          end else if (sm_rd_q.cnt < cap) begin
            e_q       <= '{head: o_q, cnt: cnt_inc, nxt: sm_rd_q.nxt, prv: sm_rd_q.prv,
                           tag: sm_rd_q.tag};
            ret_pop_q <= 1'b0;
            if (cnt_inc >= cap) begin
              mv_tag_q <= TAG_FREE;
            end else if (sm_rd_q.tag == TAG_FULL) begin
              mv_tag_q <= TAG_PART;
            end else begin
              mv_tag_q <= sm_rd_q.tag;
            end
            state_q <= MV_CHECK;
          end else begin
            state_q <= FIN;
          end
        end
        POP_RD: state_q <= POP_WR;
        POP_WR: begin
          e_q.head  <= lm_rd_q;
          e_q.cnt   <= cnt_dec;
          mv_tag_q  <= (cnt_dec == '0) ? TAG_FULL : e_q.tag;
          ret_pop_q <= 1'b0;
          res_q     <= '{status: ST_ALLOC, slab: 4'(s_q), object: 6'(e_q.head)};
          state_q   <= MV_CHECK;
        end
        MV_CHECK: begin
          if (e_q.tag == mv_tag_q) begin
            state_q <= MV_WB;
          end else if (e_q.tag == TAG_NONE) begin
            state_q <= PU;
          end else if (!is_slab(e_q.prv)) begin
            heads_q[e_q.tag] <= e_q.nxt;
            state_q          <= UL_N;
          end else begin
            state_q <= UL_P_WR;
          end
        end
        UL_P_WR: state_q <= UL_N;
        UL_N:    state_q <= is_slab(e_q.nxt) ? UL_N_WR : PU;
        UL_N_WR: state_q <= PU;
        PU: begin
          h_q               <= heads_q[mv_tag_q];
          e_q.nxt           <= heads_q[mv_tag_q];
          e_q.prv           <= NIL;
          e_q.tag           <= mv_tag_q;
          heads_q[mv_tag_q] <= LW'(s_q);
          state_q           <= is_slab(heads_q[mv_tag_q]) ? PU_WR : MV_WB;
        end
        PU_WR: state_q <= MV_WB;
        MV_WB: state_q <= ret_pop_q ? POP_RD : FIN;
        FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q <= NIL)
    else $error("pool count beyond slab count");

  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_OOM) |->
      (out_data_o.slab == '0) && (out_data_o.object == '0))
    else $error("out of memory item carries nonzero slab or object");

  a_heads_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_slab(heads_q[TAG_PART]) |->
      (heads_q[TAG_PART] != heads_q[TAG_FULL]) &&
      (heads_q[TAG_PART] != heads_q[TAG_FREE]))
    else $error("one slab heads two lists");

  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWEEP) |-> (CW'(i_q) < cap))
    else $error("threading sweep past slab capacity");

endmodule

`default_nettype wire

FILE: dv/slab_alloc_checker.sv
// checker for the slab object allocator: mirrors the slab lists and free chains,
// predicts one response per accepted request and compares it in order
// depends on soa_pkg
`default_nettype none

module slab_alloc_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_ready_i,
  input  wire soa_pkg::req_t in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_ready_i,
  input  wire soa_pkg::rsp_t out_data_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_sel_i,
  input  wire logic [31:0]   cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import soa_pkg::*;

  localparam int NS = NUM_SLABS;
  localparam int MO = MAX_OBJS;
  localparam int NIL = NS;

  logic [5:0] link_mem [NS*MO];
  logic [5:0] chain_head [NS];
  logic [6:0] free_cnt [NS];
  int         nxt [NS];
  int         prv [NS];
  tag_e       tag [NS];
  int         heads [3];
  int         taken;
  logic [6:0] cfg_objs;
  logic [4:0] cfg_limit;
  rsp_t       expected_q [$];

  function automatic int cap_now();
    int c;
    c = cfg_objs;
    if (c == 0) c = 1;
    if (c > MO) c = MO;
    return c;
  endfunction

  task automatic unlink(input int s);
    int p, n;
    p = prv[s];
    n = nxt[s];
    if (tag[s] == TAG_NONE) return;
    if (p >= NS) heads[tag[s]] = n;
    else nxt[p] = n;
    if (n < NS) prv[n] = p;
    tag[s] = TAG_NONE;
  endtask

  task automatic push_front(input int s, input tag_e l);
    int h;
    h = heads[l];
    nxt[s] = h;
    prv[s] = NIL;
    if (h < NS) prv[h] = s;
    heads[l] = s;
    tag[s] = l;
  endtask

  task automatic move_to(input int s, input tag_e l);
    if (tag[s] == l) return;
    unlink(s);
    push_front(s, l);
  endtask

  function automatic void clear_state();
    for (int i = 0; i < NS; i++) begin
      nxt[i] = NIL;
      prv[i] = NIL;
      tag[i] = TAG_NONE;
      chain_head[i] = '0;
      free_cnt[i] = '0;
    end
    for (int i = 0; i < 3; i++) heads[i] = NIL;
    taken = 0;
    cfg_objs = OBJS_PER_SLAB_RST;
    cfg_limit = SLAB_LIMIT_RST;
  endfunction

  task automatic predict_rsp(input req_t rq);
    rsp_t r;
    int cap, s, o, lim;
    cap = cap_now();
    lim = (cfg_limit > NS) ? NS : cfg_limit;
    r = '{status: ST_FREED, slab: '0, object: '0};
    if (rq.command == CMD_ALLOC) begin
      s = -1;
      if (heads[TAG_PART] < NS) s = heads[TAG_PART];
      else if (heads[TAG_FREE] < NS) begin
        s = heads[TAG_FREE];
        move_to(s, TAG_PART);
      end else if (taken < lim) begin
        s = taken;
        taken++;
        for (int i = 0; i + 1 < cap; i++) link_mem[s*MO+i] = 6'(i + 1);
        link_mem[s*MO+cap-1] = '0;
        chain_head[s] = '0;
        free_cnt[s] = 7'(cap);
        push_front(s, TAG_PART);
      end
      if (s < 0) r.status = ST_OOM;
      else begin
        o = chain_head[s];
        chain_head[s] = link_mem[s*MO+o];
        if (free_cnt[s] > 0) free_cnt[s]--;
        if (free_cnt[s] == 0) move_to(s, TAG_FULL);
        r = '{status: ST_ALLOC, slab: 4'(s), object: 6'(o)};
      end
    end else begin
      s = rq.free_slab;
      o = rq.free_object;
      if (s < taken && o < cap && free_cnt[s] < cap) begin
        link_mem[s*MO+o] = chain_head[s];
        chain_head[s] = 6'(o);
        free_cnt[s]++;
        if (free_cnt[s] >= cap) move_to(s, TAG_FREE);
        else if (tag[s] == TAG_FULL) move_to(s, TAG_PART);
      end
    end
    expected_q.push_back(r);
  endtask

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors_o++;
  endtask

  initial errors_o = 0;
  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_sel_i == REG_OBJS_PER_SLAB) cfg_objs = cfg_data_i[6:0];
        else cfg_limit = cfg_data_i[4:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) report("response with nothing expected");
        else begin
          rsp_t e;
          e = expected_q.pop_front();
          if (out_data_i.status !== e.status)
            report($sformatf("status %0d, expected %0d", out_data_i.status, e.status));
          if (out_data_i.slab !== e.slab)
            report($sformatf("slab %0d, expected %0d", out_data_i.slab, e.slab));
          if (out_data_i.object !== e.object)
            report($sformatf("object %0d, expected %0d", out_data_i.object, e.object));
        end
      end
      if (in_valid_i && in_ready_i) predict_rsp(in_data_i);
    end
  end
endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench top for slab_object_allocator_top: reset, register writes,
// directed and random alloc/free traffic; depends on soa_pkg and slab_alloc_checker
`default_nettype none

module tb;
  import soa_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  longint      cycles = 0;
  bit          sink_on = 1'b0;
  int          sink_wait = 0;
  // model of currently allocated objects to make valid frees likely
  logic [9:0]  live_q [$];

  always #10 clk = ~clk;

  slab_object_allocator_top u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  slab_alloc_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(psel && penable && pwrite && pready), .cfg_sel_i(paddr[2]),
    .cfg_data_i(pwdata), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall after each item it takes
  always @(posedge clk) begin
    if (sink_on) begin
      if (out_valid && out_ready) begin
        if (out_data.status == ST_ALLOC) live_q.push_back({out_data.slab, out_data.object});
        sink_wait = $urandom_range(0, 5);
      end else if (sink_wait != 0) begin
        sink_wait = sink_wait - 1;
      end
      out_ready <= (sink_wait == 0);
    end
  end

  task automatic reg_write(input logic sel, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {sel, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // valid stays up into the next item when no idle cycles are drawn
  task automatic send(input req_t rq);
    int w;
    w = $urandom_range(0, 5);
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_alloc();
    send('{command: CMD_ALLOC, free_slab: 4'($urandom), free_object: 6'($urandom)});
  endtask

  task automatic send_free_live();
    req_t rq;
    int k;
    logic [9:0] v;
    if (live_q.size() == 0) begin
      send_alloc();
      return;
    end
    k = $urandom_range(0, live_q.size() - 1);
    v = live_q[k];
    live_q.delete(k);
    rq = '{command: CMD_FREE, free_slab: v[9:6], free_object: v[5:0]};
    send(rq);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int alloc_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) send_alloc();
      else if (r < 95) send_free_live();
      else send('{command: CMD_FREE, free_slab: 4'($urandom), free_object: 6'($urandom)});
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    sink_on <= 1'b1;
    out_ready <= 1'b1;
    // directed: small slabs, exhaust the pool, frees of all kinds
    reg_write(REG_OBJS_PER_SLAB, 32'd2);
    reg_write(REG_SLAB_LIMIT, 32'd2);
    repeat (5) send_alloc();   // last one runs out of memory
    send('{command: CMD_FREE, free_slab: 4'd15, free_object: 6'd63}); // slab not taken
    send('{command: CMD_FREE, free_slab: 4'd0, free_object: 6'd2});   // index too big
    send('{command: CMD_FREE, free_slab: 4'd0, free_object: 6'd1});   // full back to partial
    send('{command: CMD_FREE, free_slab: 4'd0, free_object: 6'd0});   // wholly free
    send('{command: CMD_FREE, free_slab: 4'd0, free_object: 6'd0});   // already all free
    send_alloc();              // free list slab reused
    send('{command: CMD_FREE, free_slab: 4'd1, free_object: 6'd1});
    send('{command: CMD_FREE, free_slab: 4'd1, free_object: 6'd1});   // double free
    send_alloc();
    send_alloc();
    drain();
    live_q.delete();
    // out of range register values; shrink objs per slab while slabs are in use
    reg_write(REG_SLAB_LIMIT, 32'd0);
    send_alloc();
    drain();
    reg_write(REG_SLAB_LIMIT, 32'hffff_ffff);
    reg_write(REG_OBJS_PER_SLAB, 32'd0);
    send_alloc();
    send_alloc();
    drain();
    reg_write(REG_OBJS_PER_SLAB, 32'd127);
    send_alloc();
    drain();
    // random phases over several settings
    reg_write(REG_OBJS_PER_SLAB, 32'd64);
    reg_write(REG_SLAB_LIMIT, 32'd16);
    random_phase(300, 60);
    drain();
    reg_write(REG_OBJS_PER_SLAB, 32'd1);
    reg_write(REG_SLAB_LIMIT, 32'd1);
    random_phase(200, 55);
    drain();
    reg_write(REG_OBJS_PER_SLAB, 32'd4);
    reg_write(REG_SLAB_LIMIT, 32'd16);
    random_phase(350, 55);
    drain();
    reg_write(REG_OBJS_PER_SLAB, $urandom_range(1, 16));
    reg_write(REG_SLAB_LIMIT, $urandom_range(1, 16));
    random_phase(300, 50);
    drain();
    reg_write(REG_OBJS_PER_SLAB, 32'd3);
    reg_write(REG_SLAB_LIMIT, 32'd5);
    random_phase(250, 65);
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire
